FILE: rtl/core/spd_pkg.sv
// Shared types and constants of the sensor packet deframer.
// Depends on nothing; used by the top level and its port checker.
`default_nettype none

package spd_pkg;

	// Packet type bytes as they arrive on the link
	localparam logic [7:0] TYPE_SENSOR = 8'h01;
	localparam logic [7:0] TYPE_PINS   = 8'h02;
	localparam logic [7:0] TYPE_ERROR  = 8'h03;
	localparam logic [7:0] TYPE_STATUS = 8'h04;

	// Result kinds
	localparam logic [2:0] KIND_SENSOR     = 3'd0;
	localparam logic [2:0] KIND_PINS       = 3'd1;
	localparam logic [2:0] KIND_DEV_ERROR  = 3'd2;
	localparam logic [2:0] KIND_STATUS     = 3'd3;
	localparam logic [2:0] KIND_UNKNOWN    = 3'd4;
	localparam logic [2:0] KIND_INCOMPLETE = 3'd5;

	// Quiet NaN, shown for float words that were not sent
	localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

	// Float words carried by one result
	localparam int unsigned OUT_WORDS = 4;

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_FLAGS = 5'b00010,
		PH_COUNT = 5'b00100,
		PH_BODY  = 5'b01000,
		PH_ERR   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [2:0]                      kind;
		logic [7:0]                      flags;
		logic [7:0]                      item_count;
		logic [OUT_WORDS-1:0][31:0]      value;
		logic [7:0]                      dht_pin;
		logic [7:0]                      servo_pin;
	} res_t;

endpackage

`default_nettype wire

FILE: rtl/core/sensor_packet_deframer_unit.sv
// Sensor packet deframer: byte-stream parser with registered result output.
// Depends on spd_pkg for packet codes, phase type and the result struct.
`default_nettype none

// Usage
// - Input stream: one link byte per item in s_tdata, s_tlast set on the last
//   byte of a received chunk. An item is taken when s_tvalid and s_tready
//   are both high.
// - Output stream: at most one result per input byte. m_tuser carries the
//   kind, m_tdata the packet fields. A result shows on the master side the
//   cycle after the byte that completes it was accepted, unless a stalled result waits.
// - Throughput: one byte per cycle while s_tready is high. Each byte only moves
//   the parse state (phase, counters, header and word registers) through
//   combinational logic into the state and result registers.
// - Stall: a two-entry output (result register plus one skid entry) lets the
//   input keep flowing while a result waits. s_tready drops only when both
//   entries are full and comes back the cycle after m_tready takes one.
// - Reset: arst_n clears the parser to idle, awaiting a type byte, sets all
//   float words to quiet NaN and empties the output stage.
// - A packet cut off by a chunk end is dropped and reported as incomplete;
//   an unknown type byte is reported and parsing stays idle.
module sensor_packet_deframer_unit #(
	parameter int unsigned MAX_VALUES = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output      logic         s_tready,
	input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
	input  wire logic         s_tlast,   // chunk_end
	output      logic         m_tvalid,
	input  wire logic         m_tready,
	output      logic [159:0] m_tdata,   // flags, item_count, value_a, value_b,
	                                     // value_c, value_d, dht_pin, servo_pin
	output      logic [2:0]   m_tuser    // kind
);

	spd_pkg::phase_t phase_q, phase_d;
	logic [2:0]  ptype_q, ptype_d;
	logic [9:0]  rem_q, rem_d;
	logic [1:0]  biw_q, biw_d;
	logic [7:0]  widx_q, widx_d;
	logic [7:0]  hflags_q, hflags_d;
	logic [7:0]  hcount_q, hcount_d;
	logic [7:0]  dht_q, dht_d;
	logic [MAX_VALUES-1:0][31:0] words_q, words_d;
	logic [spd_pkg::OUT_WORDS-1:0][31:0] out_words;

	logic          acc_in;
	logic          emit;
	logic          res_valid;
	spd_pkg::res_t res;

	logic          out_valid_q;
	spd_pkg::res_t out_q;
	logic          skid_valid_q;
	spd_pkg::res_t skid_q;

	assign s_tready = !skid_valid_q;
	assign acc_in   = s_tvalid && s_tready;
	assign res_valid = acc_in && emit;

	// Words past the stored count always read as NaN
	for (genvar j = 0; j < spd_pkg::OUT_WORDS; j++) begin : g_out_word
		if (j < MAX_VALUES) begin : g_stored
			assign out_words[j] = words_d[j];
		end else begin : g_absent
			assign out_words[j] = spd_pkg::QNAN_BITS;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		ptype_d  = ptype_q;
		rem_d    = rem_q;
		biw_d    = biw_q;
		widx_d   = widx_q;
		hflags_d = hflags_q;
		hcount_d = hcount_q;
		dht_d    = dht_q;
		words_d  = words_q;
		emit     = 1'b0;
		res      = '0;

		unique case (phase_q)
			spd_pkg::PH_IDLE: begin
				if (s_tdata >= spd_pkg::TYPE_SENSOR && s_tdata <= spd_pkg::TYPE_STATUS) begin
					ptype_d = s_tdata[2:0];
					if (s_tdata == spd_pkg::TYPE_SENSOR) begin
						phase_d = spd_pkg::PH_FLAGS;
					end else if (s_tdata == spd_pkg::TYPE_ERROR) begin
						phase_d = spd_pkg::PH_ERR;
					end else begin
						phase_d = spd_pkg::PH_COUNT;
					end
				end else begin
					emit      = 1'b1;
					res.kind  = spd_pkg::KIND_UNKNOWN;
					res.flags = s_tdata;
				end
			end
			spd_pkg::PH_FLAGS: begin
				hflags_d = s_tdata;
				phase_d  = spd_pkg::PH_COUNT;
			end
			spd_pkg::PH_COUNT: begin
				hcount_d = s_tdata;
				widx_d   = '0;
				biw_d    = '0;
				if (ptype_q == spd_pkg::TYPE_SENSOR[2:0]) begin
					for (int i = 0; i < MAX_VALUES; i++) begin
						words_d[i] = spd_pkg::QNAN_BITS;
					end
					rem_d = {s_tdata, 2'b00};
					if (s_tdata == 8'd0) begin
						emit    = 1'b1;
						phase_d = spd_pkg::PH_IDLE;
					end else begin
						phase_d = spd_pkg::PH_BODY;
					end
				end else if (ptype_q == spd_pkg::TYPE_PINS[2:0]) begin
					rem_d = {2'b00, s_tdata};
					if (s_tdata == 8'd0) begin
						emit    = 1'b1;
						phase_d = spd_pkg::PH_IDLE;
					end else begin
						phase_d = spd_pkg::PH_BODY;
					end
				end else begin
					// analog pins plus the DHT and servo bytes
					rem_d   = {2'b00, s_tdata} + 10'd2;
					phase_d = spd_pkg::PH_BODY;
				end
			end
			spd_pkg::PH_BODY: begin
				rem_d = rem_q - 10'd1;
				if (ptype_q == spd_pkg::TYPE_SENSOR[2:0]) begin
					// little-endian assembly; words past the store are skipped
					for (int i = 0; i < MAX_VALUES; i++) begin
						if (widx_q == 8'(i)) begin
							if (biw_q == 2'd0) begin
								words_d[i] = {24'd0, s_tdata};
							end else begin
								words_d[i][8*biw_q +: 8] = s_tdata;
							end
						end
					end
					biw_d = biw_q + 2'd1;
					if (biw_q == 2'd3 && widx_q != 8'hFF) begin
						widx_d = widx_q + 8'd1;
					end
					if (rem_q == 10'd1) begin
						emit    = 1'b1;
						phase_d = spd_pkg::PH_IDLE;
					end
				end else if (ptype_q == spd_pkg::TYPE_PINS[2:0]) begin
					if (rem_q == 10'd1) begin
						emit    = 1'b1;
						phase_d = spd_pkg::PH_IDLE;
					end
				end else if (ptype_q == spd_pkg::TYPE_STATUS[2:0]) begin
					if (rem_q == 10'd2) begin
						dht_d = s_tdata;
					end
					if (rem_q == 10'd1) begin
						emit           = 1'b1;
						res.kind       = spd_pkg::KIND_STATUS;
						res.item_count = hcount_q;
						res.dht_pin    = dht_q;
						res.servo_pin  = s_tdata;
						phase_d        = spd_pkg::PH_IDLE;
					end
				end else begin
					phase_d = spd_pkg::PH_IDLE;
				end
			end
			spd_pkg::PH_ERR: begin
				emit      = 1'b1;
				res.kind  = spd_pkg::KIND_DEV_ERROR;
				res.flags = s_tdata;
				phase_d   = spd_pkg::PH_IDLE;
			end
			default: begin
				phase_d = spd_pkg::PH_IDLE;
			end
		endcase

		// Fill in completed sensor and pin packets
		if (emit && phase_q != spd_pkg::PH_IDLE && phase_q != spd_pkg::PH_ERR) begin
			if (ptype_q == spd_pkg::TYPE_SENSOR[2:0]) begin
				res.kind       = spd_pkg::KIND_SENSOR;
				res.flags      = hflags_q;
				res.item_count = hcount_d;
				res.value      = out_words;
			end else if (ptype_q == spd_pkg::TYPE_PINS[2:0]) begin
				res.kind       = spd_pkg::KIND_PINS;
				res.item_count = hcount_d;
			end
		end

		// Drop a packet cut off by the chunk end
		if (!emit && s_tlast && phase_d != spd_pkg::PH_IDLE) begin
			res       = '0;
			res.kind  = spd_pkg::KIND_INCOMPLETE;
			res.flags = {5'd0, ptype_d};
			emit      = 1'b1;
			phase_d   = spd_pkg::PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= spd_pkg::PH_IDLE;
			ptype_q  <= '0;
			rem_q    <= '0;
			biw_q    <= '0;
			widx_q   <= '0;
			hflags_q <= '0;
			hcount_q <= '0;
			dht_q    <= '0;
			for (int i = 0; i < MAX_VALUES; i++) begin
				words_q[i] <= spd_pkg::QNAN_BITS;
			end
		end else if (acc_in) begin
			phase_q  <= phase_d;
			ptype_q  <= ptype_d;
			rem_q    <= rem_d;
			biw_q    <= biw_d;
			widx_q   <= widx_d;
			hflags_q <= hflags_d;
			hcount_q <= hcount_d;
			dht_q    <= dht_d;
			words_q  <= words_d;
		end
	end

	// Output register plus one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (res_valid) begin
				out_q <= res;
			end
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.kind;
	assign m_tdata  = {out_q.servo_pin, out_q.dht_pin,
	                   out_q.value[3], out_q.value[2], out_q.value[1], out_q.value[0],
	                   out_q.item_count, out_q.flags};

endmodule

`default_nettype wire

FILE: rtl/core/spd_checker.sv
// Port-level checks for the sensor packet deframer, bound to its top level.
// Depends on spd_pkg for the result kind codes.
`default_nettype none

module spd_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [159:0] m_tdata,
	input wire logic [2:0]   m_tuser
);

	// Hold a stalled result
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Input backpressure only comes from a waiting result
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// An unknown-type report never carries a known type byte
	a_unknown_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spd_pkg::KIND_UNKNOWN |->
			(m_tdata[7:0] == 8'd0 || m_tdata[7:0] > spd_pkg::TYPE_STATUS))
		else $error("known type reported as unknown");

	// An incomplete report names a known packet type
	a_incomplete_type: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == spd_pkg::KIND_INCOMPLETE |->
			(m_tdata[7:0] >= spd_pkg::TYPE_SENSOR && m_tdata[7:0] <= spd_pkg::TYPE_STATUS))
		else $error("incomplete report with bad type");

endmodule

bind sensor_packet_deframer_unit spd_checker u_spd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

FILE: bench/deframe_check.sv
// Port checker for the sensor packet deframer: follows both streams, predicts
// each result from the accepted bytes and compares it field by field.
// Depends on spd_pkg for packet codes, the phase enum and the result struct.
`default_nettype none

module deframe_check import spd_pkg::*; #(
	parameter int unsigned MAX_VALUES = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [7:0]   s_tdata,
	input  wire logic         s_tlast,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [159:0] m_tdata,
	input  wire logic [2:0]   m_tuser,
	output      int           errors,
	output      int           pending
);

	// Parser state as the block should hold it
	phase_t      ph;
	logic [7:0]  pkt_type;
	logic [9:0]  left;
	logic [1:0]  byte_pos;
	logic [7:0]  word_no;
	logic [31:0] words [OUT_WORDS];
	logic [7:0]  hdr_flags;
	logic [7:0]  hdr_count;
	logic [7:0]  dht_keep;

	res_t results_due [$];

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	function automatic res_t sensor_record();
		res_t r;
		r = '0;
		r.kind = KIND_SENSOR;
		r.flags = hdr_flags;
		r.item_count = hdr_count;
		for (int i = 0; i < OUT_WORDS; i++)
			r.value[i] = words[i];
		return r;
	endfunction

	function automatic res_t pin_update();
		res_t r;
		r = '0;
		r.kind = KIND_PINS;
		r.item_count = hdr_count;
		return r;
	endfunction

	// Advance the parse by one byte and queue the result it causes, if any
	task automatic deframe_byte(input logic [7:0] b, input logic last);
		res_t r;
		logic emit;
		logic [31:0] v;
		r = '0;
		emit = 1'b0;
		case (ph)
			PH_IDLE: begin
				if (b >= TYPE_SENSOR && b <= TYPE_STATUS) begin
					pkt_type = b;
					if (b == TYPE_SENSOR)
						ph = PH_FLAGS;
					else if (b == TYPE_ERROR)
						ph = PH_ERR;
					else
						ph = PH_COUNT;
				end else begin
					r.kind = KIND_UNKNOWN;
					r.flags = b;
					emit = 1'b1;
				end
			end
			PH_FLAGS: begin
				hdr_flags = b;
				ph = PH_COUNT;
			end
			PH_COUNT: begin
				hdr_count = b;
				word_no = '0;
				byte_pos = '0;
				if (pkt_type == TYPE_SENSOR) begin
					for (int i = 0; i < OUT_WORDS; i++)
						words[i] = QNAN_BITS;
					left = {b, 2'b00};
					if (b == 8'd0) begin
						r = sensor_record();
						emit = 1'b1;
						ph = PH_IDLE;
					end else
						ph = PH_BODY;
				end else if (pkt_type == TYPE_PINS) begin
					left = {2'b00, b};
					if (b == 8'd0) begin
						r = pin_update();
						emit = 1'b1;
						ph = PH_IDLE;
					end else
						ph = PH_BODY;
				end else begin
					left = {2'b00, b} + 10'd2;
					ph = PH_BODY;
				end
			end
			PH_BODY: begin
				if (pkt_type == TYPE_SENSOR) begin
					// words past the kept ones are consumed and dropped
					if (word_no < MAX_VALUES && word_no < OUT_WORDS) begin
						v = {24'h0, b} << {byte_pos, 3'b000};
						if (byte_pos == 2'd0)
							words[word_no] = v;
						else
							words[word_no] = words[word_no] | v;
					end
					byte_pos = byte_pos + 2'd1;
					if (byte_pos == 2'd0 && word_no != 8'hFF)
						word_no = word_no + 8'd1;
					left = left - 10'd1;
					if (left == 10'd0) begin
						r = sensor_record();
						emit = 1'b1;
						ph = PH_IDLE;
					end
				end else if (pkt_type == TYPE_PINS) begin
					if (word_no != 8'hFF)
						word_no = word_no + 8'd1;
					left = left - 10'd1;
					if (left == 10'd0) begin
						r = pin_update();
						emit = 1'b1;
						ph = PH_IDLE;
					end
				end else if (pkt_type == TYPE_STATUS) begin
					if (left == 10'd2)
						dht_keep = b;
					if (left == 10'd1) begin
						r.kind = KIND_STATUS;
						r.item_count = hdr_count;
						r.dht_pin = dht_keep;
						r.servo_pin = b;
						emit = 1'b1;
						ph = PH_IDLE;
					end
					left = left - 10'd1;
				end else
					ph = PH_IDLE;
			end
			PH_ERR: begin
				r.kind = KIND_DEV_ERROR;
				r.flags = b;
				emit = 1'b1;
				ph = PH_IDLE;
			end
			default: ph = PH_IDLE;
		endcase
		// a chunk that ends mid-packet drops the packet
		if (!emit && last && ph != PH_IDLE) begin
			r = '0;
			r.kind = KIND_INCOMPLETE;
			r.flags = pkt_type;
			ph = PH_IDLE;
			emit = 1'b1;
		end
		if (emit)
			results_due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			ph = PH_IDLE;
			pkt_type = '0;
			left = '0;
			byte_pos = '0;
			word_no = '0;
			for (int i = 0; i < OUT_WORDS; i++)
				words[i] = QNAN_BITS;
			hdr_flags = '0;
			hdr_count = '0;
			dht_keep = '0;
			results_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0)
					note_mismatch("result with none pending", {29'h0, m_tuser}, 32'h0);
				else begin
					want = results_due.pop_front();
					if (m_tuser !== want.kind)
						note_mismatch("kind", {29'h0, m_tuser}, {29'h0, want.kind});
					if (m_tdata[7:0] !== want.flags)
						note_mismatch("flags", {24'h0, m_tdata[7:0]}, {24'h0, want.flags});
					if (m_tdata[15:8] !== want.item_count)
						note_mismatch("item_count", {24'h0, m_tdata[15:8]},
							{24'h0, want.item_count});
					for (int i = 0; i < OUT_WORDS; i++)
						if (m_tdata[16 + 32*i +: 32] !== want.value[i])
							note_mismatch($sformatf("value word %0d", i),
								m_tdata[16 + 32*i +: 32], want.value[i]);
					if (m_tdata[151:144] !== want.dht_pin)
						note_mismatch("dht_pin", {24'h0, m_tdata[151:144]},
							{24'h0, want.dht_pin});
					if (m_tdata[159:152] !== want.servo_pin)
						note_mismatch("servo_pin", {24'h0, m_tdata[159:152]},
							{24'h0, want.servo_pin});
				end
			end
			if (s_tvalid && s_tready)
				deframe_byte(s_tdata, s_tlast);
			pending = results_due.size();
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// Top of the deframer bench: clock, reset, byte stimulus and result sink.
// Depends on spd_pkg, sensor_packet_deframer_unit and deframe_check.
`default_nettype none

module tb_top;
	import spd_pkg::*;

	localparam int unsigned MAX_VALUES = 4;
	localparam int RANDOM_BYTES = 1950;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [7:0]   s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [159:0] m_tdata;
	logic [2:0]   m_tuser;
	int           errors;
	int           pending;

	logic [8:0] frame_q [$];   // {chunk_end, byte}
	bit         burst_mode;
	bit         hold_req;
	int         idle_cycles = 0;

	sensor_packet_deframer_unit #(.MAX_VALUES(MAX_VALUES)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	deframe_check #(.MAX_VALUES(MAX_VALUES)) frame_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// End the run if nothing moves on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_byte(input logic [7:0] b);
		frame_q.push_back({1'b0, b});
	endtask

	function automatic logic [7:0] unknown_type();
		int b;
		b = $urandom_range(5, 256);
		return (b == 256) ? 8'h00 : b[7:0];
	endfunction

	task automatic make_packet(input logic [7:0] type_byte, input int count);
		logic [7:0] cnt;
		cnt = count[7:0];
		add_byte(type_byte);
		case (type_byte)
			TYPE_SENSOR: begin
				add_byte(8'($urandom_range(0, 255)));
				add_byte(cnt);
				repeat (4 * cnt) add_byte(8'($urandom_range(0, 255)));
			end
			TYPE_PINS: begin
				add_byte(cnt);
				repeat (cnt) add_byte(8'($urandom_range(0, 255)));
			end
			TYPE_ERROR: add_byte(8'($urandom_range(0, 255)));
			TYPE_STATUS: begin
				add_byte(cnt);
				repeat (cnt + 2) add_byte(8'($urandom_range(0, 255)));
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [8:0] it);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it[7:0];
		s_tlast <= it[8];
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	// Send the built frame; a cut truncates it and ends the chunk there
	task automatic ship(input int cut, input bit end_flag);
		if (cut >= 0 && cut < frame_q.size()) begin
			frame_q = frame_q[0:cut];
			frame_q[cut][8] = 1'b1;
		end else if (end_flag)
			frame_q[frame_q.size() - 1][8] = 1'b1;
		foreach (frame_q[i])
			send_item(frame_q[i]);
		frame_q.delete();
	endtask

	// Hold the input until every predicted result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Result sink
	initial begin
		bit calm;
		int gap;
		calm = 1'b0;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			if ($urandom_range(0, 40) == 0)
				calm = !calm;
			gap = calm ? 0 : $urandom_range(0, 5);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
		end
	end

	// Byte source
	initial begin
		int pkt_no;
		int small_bytes;
		int sel;
		int cut;
		int n;
		bit end_flag;
		logic [7:0] t;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		burst_mode = 1'b0;
		hold_req = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unknown type bytes, one of them closing a chunk
		add_byte(8'h00);
		add_byte(8'hFF);
		ship(-1, 1'b0);
		add_byte(8'h05);
		ship(-1, 1'b1);
		// device error whose code byte also ends the chunk
		add_byte(TYPE_ERROR);
		add_byte(8'hFF);
		ship(-1, 1'b1);
		// zero counts: sensor and pin list finish on the count byte
		add_byte(TYPE_SENSOR);
		add_byte(8'hA5);
		add_byte(8'h00);
		add_byte(TYPE_PINS);
		add_byte(8'h00);
		// status with no analog pins still takes DHT and servo bytes
		add_byte(TYPE_STATUS);
		add_byte(8'h00);
		add_byte(8'h00);
		add_byte(8'hFF);
		ship(-1, 1'b0);
		// chunk ends right on a type byte
		add_byte(TYPE_PINS);
		ship(-1, 1'b1);
		// one float word, the rest read as NaN
		add_byte(TYPE_SENSOR);
		add_byte(8'h5A);
		add_byte(8'h01);
		add_byte(8'h78);
		add_byte(8'h56);
		add_byte(8'h34);
		add_byte(8'h12);
		ship(-1, 1'b0);
		// status cut off inside its body
		add_byte(TYPE_STATUS);
		add_byte(8'h03);
		add_byte(8'h11);
		ship(-1, 1'b1);
		drain();

		// back up the output while the input keeps offering results
		hold_req = 1'b1;
		burst_mode = 1'b1;
		repeat (12) add_byte(unknown_type());
		ship(-1, 1'b0);
		burst_mode = 1'b0;
		drain();

		pkt_no = 0;
		small_bytes = 0;
		while (small_bytes < RANDOM_BYTES) begin
			pkt_no++;
			burst_mode = ($urandom_range(0, 3) == 0);
			cut = -1;
			end_flag = ($urandom_range(0, 2) == 0);
			if (pkt_no == 5)
				make_packet(TYPE_SENSOR, 255);
			else if (pkt_no == 10)
				make_packet(TYPE_PINS, 255);
			else if (pkt_no == 15)
				make_packet(TYPE_STATUS, 255);
			else begin
				sel = $urandom_range(0, 99);
				if (sel < 30)
					make_packet(TYPE_SENSOR, ($urandom_range(0, 9) == 0) ?
						$urandom_range(7, 40) : $urandom_range(0, 6));
				else if (sel < 50)
					make_packet(TYPE_PINS, ($urandom_range(0, 4) == 0) ?
						$urandom_range(30, 45) : $urandom_range(0, 12));
				else if (sel < 62)
					make_packet(TYPE_ERROR, 0);
				else if (sel < 80)
					make_packet(TYPE_STATUS, $urandom_range(0, 8));
				else if (sel < 88)
					make_packet(unknown_type(), 0);
				else if (sel < 94) begin
					// broken packet: chunk ends before it completes
					t = 8'($urandom_range(1, 4));
					make_packet(t, $urandom_range(0, 255));
					n = frame_q.size() - 2;
					cut = $urandom_range(0, (n < 12) ? n : 12);
				end else begin
					// noise; closing the chunk brings the parser back to idle
					n = $urandom_range(1, 6);
					repeat (n)
						frame_q.push_back({1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
					end_flag = 1'b1;
				end
			end
			small_bytes += (cut >= 0) ? cut + 1 : frame_q.size();
			ship(cut, end_flag);
			if (pkt_no % 100 == 0)
				drain();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
